/* sv/scc_pkg.sv */
// Shared types and codes of the sector cache tag and replacement engine.
`timescale 1ns / 1ps

package scc_pkg;

  // Request kinds carried on the input tuser.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  // Width of the slot field in a result.
  localparam int unsigned SLOT_W = 6;

  // Width of a sector number.
  localparam int unsigned SECTOR_W = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SWEEP,
    ST_VRD,
    ST_VCHK,
    ST_EMIT,
    ST_FLUSH,
    ST_FLUSH_END
  } state_t;

  // One result item.
  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic                fetch;
    logic                wb;
    logic [SECTOR_W-1:0] wb_sector;
    logic                last;
  } res_t;

endpackage

/* sv/scc_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module scc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/sector_cache_clock_replacement_top.sv */
// Top level of the sector cache tag store and clock replacement engine.
`timescale 1ns / 1ps

// Tag and policy engine of a fully associative sector cache, clock replacement.
// Input channel s_axis: one request per transfer, tuser = command (read, write,
// flush), tdata = sector number. Output channel m_axis: result transfers, tlast
// marks the final result of a request (every read or write result, the last
// flushed slot of a flush, or an empty result if a flush finds no dirty slot).
// The tags sit in one RAM with a registered read port, walked one slot a cycle
// by a single compare unit; a flush walk pauses while a result is held back. A
// miss takes the lowest free slot if there is one; otherwise the clock sweep
// walks the hand and then reads the victim tag. The block takes one request at
// a time: s_axis_tready is high only while no request is at work. A finished
// result waits in the output register, so the next request is accepted while
// it is held.
// Reset clears all valid, dirty and reference bits and the hand at once; the
// tag RAM is left as it is, since a tag is only compared for a valid slot.
// When the receiver stalls, the result register holds; a flush freezes its
// slot walk until the waiting result is transferred.
module sector_cache_clock_replacement_top #(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sector
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] hit, [6:1] slot, [7] fetch_needed, [8] writeback_needed,
  // [40:9] writeback_sector, [47:41] zero
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int unsigned IW = $clog2(SLOT_COUNT);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

  scc_pkg::state_t state, state_next;

  // Slot walk: issue index, index of the slot whose tag is on the RAM output.
  logic [IW-1:0] idx;
  logic [IW-1:0] cidx;
  logic          issue_done;
  logic          chk;

  logic [IW-1:0] hand;
  logic [SLOT_COUNT-1:0] valid;
  logic [SLOT_COUNT-1:0] dirty;
  logic [SLOT_COUNT-1:0] refd;

  logic [31:0]   sector_r;
  logic          is_write;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] victim;

  // Flush holds back one dirty slot so the final one can carry tlast.
  logic          pend_valid;
  logic [IW-1:0] pend_slot;
  logic [31:0]   pend_tag;

  scc_pkg::res_t res;
  scc_pkg::res_t out_res;
  scc_pkg::res_t out_next;
  logic          out_valid;

  // RAM port signals.
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [31:0]   wr_data;

  logic in_fire;
  logic out_busy;
  logic hit_now;
  logic vd_now;
  logic stall;
  logic last_chk;
  logic out_load;
  logic vic_wb;

  function automatic logic [scc_pkg::SLOT_W-1:0] SLOT_W_CAST(input logic [IW-1:0] s);
    return scc_pkg::SLOT_W'(s);
  endfunction

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_busy = out_valid && !m_axis_tready;
  assign hit_now  = (state == scc_pkg::ST_SEARCH) && chk && valid[cidx]
                    && (rd_data == sector_r);
  assign vd_now   = (state == scc_pkg::ST_FLUSH) && chk && valid[cidx] && dirty[cidx];
  assign stall    = vd_now && pend_valid && out_busy;
  assign last_chk = chk && (cidx == LAST_IDX);
  assign vic_wb   = valid[victim] && dirty[victim];

  scc_ram #(
    .WIDTH(32),
    .DEPTH(SLOT_COUNT)
  ) u_tag_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      scc_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser == scc_pkg::CMD_READ || s_axis_tuser == scc_pkg::CMD_WRITE) begin
            state_next = scc_pkg::ST_SEARCH;
          end else if (s_axis_tuser == scc_pkg::CMD_FLUSH) begin
            state_next = scc_pkg::ST_FLUSH;
          end
        end
      end
      scc_pkg::ST_SEARCH: begin
        if (hit_now) begin
          state_next = scc_pkg::ST_EMIT;
        end else if (last_chk) begin
          if (free_found || !valid[cidx]) begin
            state_next = scc_pkg::ST_VCHK;
          end else begin
            state_next = scc_pkg::ST_SWEEP;
          end
        end
      end
      scc_pkg::ST_SWEEP: begin
        if (!refd[hand]) begin
          state_next = scc_pkg::ST_VRD;
        end
      end
      scc_pkg::ST_VRD: begin
        state_next = scc_pkg::ST_VCHK;
      end
      scc_pkg::ST_VCHK: begin
        state_next = scc_pkg::ST_EMIT;
      end
      scc_pkg::ST_EMIT: begin
        if (!out_busy) begin
          state_next = scc_pkg::ST_IDLE;
        end
      end
      scc_pkg::ST_FLUSH: begin
        if (last_chk && !stall) begin
          state_next = scc_pkg::ST_FLUSH_END;
        end
      end
      scc_pkg::ST_FLUSH_END: begin
        if (!out_busy) begin
          state_next = scc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = scc_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: RAM ports, input ready, result loading.
  always_comb begin
    s_axis_tready = (state == scc_pkg::ST_IDLE);
    rd_en    = 1'b0;
    rd_addr  = idx;
    wr_en    = (state == scc_pkg::ST_VCHK);
    wr_addr  = victim;
    wr_data  = sector_r;
    out_load = 1'b0;
    out_next = res;
    unique case (state)
      scc_pkg::ST_SEARCH, scc_pkg::ST_FLUSH: begin
        rd_en = !issue_done && !stall;
        // Pass the held slot on before a newly found dirty one takes its place.
        if (vd_now && pend_valid && !out_busy) begin
          out_load           = 1'b1;
          out_next           = '0;
          out_next.slot      = SLOT_W_CAST(pend_slot);
          out_next.wb        = 1'b1;
          out_next.wb_sector = pend_tag;
        end
      end
      scc_pkg::ST_VRD: begin
        rd_en   = 1'b1;
        rd_addr = victim;
      end
      scc_pkg::ST_EMIT: begin
        out_load = !out_busy;
      end
      scc_pkg::ST_FLUSH_END: begin
        out_load      = !out_busy;
        out_next      = '0;
        out_next.last = 1'b1;
        if (pend_valid) begin
          out_next.slot      = SLOT_W_CAST(pend_slot);
          out_next.wb        = 1'b1;
          out_next.wb_sector = pend_tag;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= scc_pkg::ST_IDLE;
      idx        <= '0;
      issue_done <= 1'b0;
      chk        <= 1'b0;
      hand       <= '0;
      valid      <= '0;
      dirty      <= '0;
      refd       <= '0;
      free_found <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (out_load) begin
        out_valid <= 1'b1;
        out_res   <= out_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        scc_pkg::ST_IDLE: begin
          if (in_fire) begin
            sector_r   <= s_axis_tdata;
            is_write   <= (s_axis_tuser == scc_pkg::CMD_WRITE);
            idx        <= '0;
            issue_done <= 1'b0;
            chk        <= 1'b0;
            free_found <= 1'b0;
            pend_valid <= 1'b0;
          end
        end
        scc_pkg::ST_SEARCH, scc_pkg::ST_FLUSH: begin
          // Advance the walk unless a flush result is blocked.
          if (!stall) begin
            if (!issue_done) begin
              cidx <= idx;
              chk  <= 1'b1;
              idx  <= idx + 1'b1;
              if (idx == LAST_IDX) begin
                issue_done <= 1'b1;
              end
            end else begin
              chk <= 1'b0;
            end
          end
          if (state == scc_pkg::ST_SEARCH) begin
            if (chk && !valid[cidx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= cidx;
            end
            if (hit_now) begin
              refd[cidx] <= 1'b1;
              if (is_write) begin
                dirty[cidx] <= 1'b1;
              end
              res <= '{hit: 1'b1, slot: SLOT_W_CAST(cidx), fetch: 1'b0,
                       wb: 1'b0, wb_sector: '0, last: 1'b1};
            end else if (last_chk) begin
              if (free_found) begin
                victim <= free_idx;
              end else if (!valid[cidx]) begin
                victim <= cidx;
              end
            end
          end else if (vd_now && !stall) begin
            pend_valid <= 1'b1;
            pend_slot  <= cidx;
            pend_tag   <= rd_data;
          end
        end
        scc_pkg::ST_SWEEP: begin
          // Second chance: clear a set reference bit, stop at a clear one.
          if (refd[hand]) begin
            refd[hand] <= 1'b0;
          end else begin
            victim <= hand;
          end
          hand <= (hand == LAST_IDX) ? '0 : hand + 1'b1;
        end
        scc_pkg::ST_VCHK: begin
          // Report the old tag only when the victim holds dirty data.
          res <= '{hit: 1'b0, slot: SLOT_W_CAST(victim), fetch: 1'b1,
                   wb: vic_wb, wb_sector: (vic_wb ? rd_data : 32'd0), last: 1'b1};
          valid[victim] <= 1'b1;
          refd[victim]  <= 1'b1;
          dirty[victim] <= is_write;
        end
        scc_pkg::ST_FLUSH_END: begin
          if (!out_busy) begin
            pend_valid <= 1'b0;
            dirty      <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_res.last;
  assign m_axis_tdata  = {7'b0, out_res.wb_sector, out_res.wb, out_res.fetch,
                          out_res.slot, out_res.hit};

`ifndef SYNTHESIS
  // A dirty slot is always a valid one.
  a_dirty_valid: assert property (@(posedge clk) disable iff (rst)
    (dirty & ~valid) == '0)
    else $error("dirty bit set on an invalid slot");

  // The clock sweep only runs with every slot valid.
  a_sweep_full: assert property (@(posedge clk) disable iff (rst)
    state == scc_pkg::ST_SWEEP |-> &valid)
    else $error("clock sweep with a free slot");

  // A tag match ends the search with its result next.
  a_hit_emit: assert property (@(posedge clk) disable iff (rst)
    hit_now |=> state == scc_pkg::ST_EMIT)
    else $error("hit did not lead to a result");

  // A completed flush leaves no dirty slot.
  a_flush_clean: assert property (@(posedge clk) disable iff (rst)
    (state == scc_pkg::ST_FLUSH_END && !out_busy) |=> dirty == '0)
    else $error("dirty bits left after flush");
`endif

endmodule

/* tb/tb_sector_cache_pkg.sv */
// Scoreboard for the sector cache tag engine: predicts results and checks them.
`timescale 1ns / 1ps

package sector_cache_tb_pkg;
  import scc_pkg::*;

  localparam int SLOTS = 64;

  class cache_scoreboard;
    bit [SECTOR_W-1:0] tags [SLOTS];
    bit [SLOTS-1:0]    valid;
    bit [SLOTS-1:0]    dirty;
    bit [SLOTS-1:0]    refd;
    int unsigned       hand;
    res_t              expected_results [$];
    int                mismatches;

    function new();
      valid = '0;
      dirty = '0;
      refd = '0;
      hand = 0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction

    // Lowest free slot first, otherwise sweep from the hand giving a second chance.
    function int find_victim();
      int h;
      for (int i = 0; i < SLOTS; i++) begin
        if (!valid[i]) return i;
      end
      forever begin
        h = hand;
        hand = (hand + 1) % SLOTS;
        if (refd[h]) refd[h] = 1'b0;
        else return h;
      end
    endfunction

    function void note_request(logic [1:0] cmd, logic [SECTOR_W-1:0] sector);
      res_t r;
      int   victim;
      int   count;
      if (cmd == CMD_READ || cmd == CMD_WRITE) begin
        r = '0;
        r.last = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          if (valid[i] && tags[i] == sector) begin
            refd[i] = 1'b1;
            if (cmd == CMD_WRITE) dirty[i] = 1'b1;
            r.hit = 1'b1;
            r.slot = SLOT_W'(i);
            expected_results.push_back(r);
            return;
          end
        end
        victim = find_victim();
        r.slot = SLOT_W'(victim);
        r.fetch = 1'b1;
        if (valid[victim] && dirty[victim]) begin
          r.wb = 1'b1;
          r.wb_sector = tags[victim];
        end
        tags[victim] = sector;
        valid[victim] = 1'b1;
        dirty[victim] = (cmd == CMD_WRITE);
        refd[victim] = 1'b1;
        expected_results.push_back(r);
      end else if (cmd == CMD_FLUSH) begin
        count = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (valid[i] && dirty[i]) begin
            r = '0;
            r.slot = SLOT_W'(i);
            r.wb = 1'b1;
            r.wb_sector = tags[i];
            expected_results.push_back(r);
            count++;
          end
        end
        dirty = '0;
        if (count == 0) begin
          r = '0;
          r.last = 1'b1;
          expected_results.push_back(r);
        end else begin
          expected_results[expected_results.size() - 1].last = 1'b1;
        end
      end
    endfunction

    function void check_result(logic [47:0] data, logic tlast);
      res_t want;
      res_t got;
      got.hit = data[0];
      got.slot = data[6:1];
      got.fetch = data[7];
      got.wb = data[8];
      got.wb_sector = data[40:9];
      got.last = tlast;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected result hit=%0b slot=%0d fetch=%0b wb=%0b sec=%h last=%0b",
                   got.hit, got.slot, got.fetch, got.wb, got.wb_sector, got.last);
        return;
      end
      want = expected_results.pop_front();
      if (got !== want || data[47:41] !== '0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: want hit=%0b slot=%0d fetch=%0b wb=%0b sec=%h last=%0b pad=0",
                   want.hit, want.slot, want.fetch, want.wb, want.wb_sector, want.last);
          $display("          got  hit=%0b slot=%0d fetch=%0b wb=%0b sec=%h last=%0b pad=%h",
                   got.hit, got.slot, got.fetch, got.wb, got.wb_sector, got.last,
                   data[47:41]);
        end
      end
    endfunction
  endclass

endpackage

/* tb/tb_top.sv */
// Top-level testbench of the sector cache tag store and clock replacement engine.
`timescale 1ns / 1ps

module tb_top;
  import scc_pkg::*;
  import sector_cache_tb_pkg::*;

  // The drain wait covers the slowest request once the receiver takes.
  localparam int DRAIN_CYCLES = 4 * SLOTS;
  // Worst case: every request a full flush with each transfer held by the longest
  // stall, plus the longest sender gap, several times over.
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // [31:0] sector
  logic [1:0]  s_axis_tuser = CMD_READ;  // [1:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] hit, [6:1] slot, [7] fetch_needed, [8] writeback_needed,
  // [40:9] writeback_sector, [47:41] zero
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  cache_scoreboard board = new();

  // Sender pacing and receiver stall pattern.
  int burst_left = 0;
  int ready_left = 0;
  int stall_left = 0;
  int cycles = 0;

  // Sector pool: slightly more sectors than slots, so the cache fills, hits often
  // and then has to evict through the clock sweep.
  logic [31:0] sector_pool [72];

  sector_cache_clock_replacement_top #(.SLOT_COUNT(SLOTS)) dut (.*);

  always #5 clk = ~clk;

  // Give up on a hang.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: runs of ready separated by stalls of random length, some runs
  // with no stall at all.
  always @(negedge clk) begin
    if (ready_left != 0) begin
      m_axis_tready <= 1'b1;
      ready_left--;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      ready_left = $urandom_range(1, 40);
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      m_axis_tready <= 1'b1;
    end
  end

  // Check every result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata, m_axis_tlast);
  end

  // Offer one request and hold it until the transfer. Entered and left at a
  // falling edge, so valid sees a single assignment per step.
  task automatic send_request(input logic [1:0] cmd, input logic [31:0] sector);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 80);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= sector;
    s_axis_tuser <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    board.note_request(cmd, sector);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_sector();
    if ($urandom_range(0, 99) < 85)
      return sector_pool[$urandom_range(0, 71)];
    return $urandom;
  endfunction

  initial begin
    int pick;
    int issued;
    logic [1:0] cmd;
    foreach (sector_pool[i]) sector_pool[i] = $urandom;

    // Hold reset, then release it at a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extreme sectors, hits on both commands, flush with and without
    // dirty slots, and the unused command code, which must pass silently.
    send_request(CMD_READ, 32'h0000_0000);
    send_request(CMD_WRITE, 32'hFFFF_FFFF);
    send_request(CMD_READ, 32'hFFFF_FFFF);
    send_request(CMD_WRITE, 32'h0000_0000);
    send_request(CMD_UNUSED, 32'hFFFF_FFFF);
    send_request(CMD_FLUSH, 32'h0000_0000);
    send_request(CMD_FLUSH, 32'hFFFF_FFFF);
    send_request(CMD_WRITE, 32'hAAAA_AAAA);
    send_request(CMD_WRITE, 32'h5555_5555);
    send_request(CMD_READ, 32'hAAAA_AAAA);
    send_request(CMD_WRITE, 32'h5555_5555);
    send_request(CMD_READ, 32'h8000_0001);
    send_request(CMD_FLUSH, 32'h5555_5555);
    send_request(CMD_UNUSED, 32'h0000_0000);
    send_request(CMD_READ, 32'h0000_0000);

    // Random: mostly reads and writes over the pool, some flushes, a little
    // noise on the unused code that does not count as an item.
    issued = 0;
    while (issued < 220) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) cmd = CMD_READ;
      else if (pick < 88) cmd = CMD_WRITE;
      else if (pick < 95) cmd = CMD_FLUSH;
      else cmd = CMD_UNUSED;
      send_request(cmd, pick_sector());
      if (cmd != CMD_UNUSED) issued++;
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then give a stray result time to show up.
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
